// File: hdl/fdcd_pkg.sv
// ----------------------------------------------------------------------------
// fdcd_pkg
// Shared constants and types for the frame difference change detector.
// ----------------------------------------------------------------------------
package fdcd_pkg;

  localparam int FRAME_PIXELS = 65536;
  localparam int ADDR_W       = $clog2(FRAME_PIXELS);
  localparam int POS_W        = ADDR_W + 1;
  localparam int PIX_W        = 8;
  localparam int CNT_W        = 17;
  localparam int CFG_IDX_W    = 2;
  localparam int TDATA_IN_W   = 8;
  localparam int TDATA_OUT_W  = 32;
  localparam int TUSER_OUT_W  = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX           = 17'd65536;
  localparam logic [PIX_W-1:0] PIXEL_THRESHOLD_RST = 8'd40;
  localparam logic [CNT_W-1:0] COUNT_THRESHOLD_RST = 17'd1000;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_THRESHOLD = 2'd1;

  // Per-pixel flags carried alongside the memory read
  typedef struct packed {
    logic capturing;
    logic in_range;
    logic last;
  } pix_flags_t;

  // One scored result
  typedef struct packed {
    logic [PIX_W-1:0] diff_value;
    logic             capturing_reference;
    logic             frame_done;
    logic [CNT_W-1:0] changed_count;
    logic             frame_changed;
    logic [CNT_W-1:0] running_next;
  } score_t;

endpackage

// File: hdl/fdcd_score.sv
// ----------------------------------------------------------------------------
// fdcd_score
// Absolute difference against the reference pixel, thresholding and the
// saturating changed-pixel count for one pixel.
// ----------------------------------------------------------------------------
module fdcd_score
  import fdcd_pkg::*;
(
  input  logic [PIX_W-1:0] pixel,
  input  logic [PIX_W-1:0] ref_pixel,
  input  pix_flags_t       flags,
  input  logic [PIX_W-1:0] pixel_threshold,
  input  logic [CNT_W-1:0] count_threshold,
  input  logic [CNT_W-1:0] running_count,
  output score_t           score
);

  logic [PIX_W-1:0] diff;
  logic [CNT_W-1:0] count_next;
  logic             hit;

  always_comb begin
    if (!flags.capturing && flags.in_range) begin
      diff = (pixel >= ref_pixel) ? (pixel - ref_pixel) : (ref_pixel - pixel);
    end else begin
      diff = '0;
    end
    hit = (diff > pixel_threshold) && (running_count < COUNT_MAX);
    if (flags.capturing) begin
      count_next = '0;
    end else if (hit) begin
      count_next = running_count + CNT_W'(1);
    end else begin
      count_next = running_count;
    end

    score.diff_value          = diff;
    score.capturing_reference = flags.capturing;
    score.frame_done          = flags.last;
    score.changed_count       = count_next;
    score.frame_changed       = flags.last && !flags.capturing &&
                                (count_next > count_threshold);
    // restart the count at frame end
    score.running_next        = flags.last ? '0 : count_next;
  end

endmodule

// File: hdl/frame_difference_change_detector_core.sv
// Pipeline: two register stages; a result moves from stage 1 into the output
//   register and onto m_tvalid when m_tready does not stall the output.
// Throughput: one pixel per cycle unless m_tready stalls, set by the single-port
//   reference store (one read or one write per pixel) and the one-pixel count update.
// Reset: clears pixel position, reference flag, running count, pipeline valids
//   and thresholds (40 and 1000); the reference store is not cleared.
// ----------------------------------------------------------------------------
// frame_difference_change_detector_core
// Stores the first frame after reset as the reference, then streams the
// absolute difference of each pixel and a per-frame change verdict.
// ----------------------------------------------------------------------------
module frame_difference_change_detector_core
  import fdcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_IN_W-1:0]  s_tdata,   // [7:0] pixel_value
  input  logic                   s_tlast,   // frame_last
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,   // [7:0] diff_value, [24:8] changed_count
  output logic [TUSER_OUT_W-1:0] m_tuser,   // [0] capturing_reference, [1] frame_changed
  output logic                   m_tlast,   // frame_done
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CNT_W-1:0]       cfg_data
);

  logic [PIX_W-1:0]  ref_mem [FRAME_PIXELS];
  logic [PIX_W-1:0]  ref_rdata;

  logic [POS_W-1:0]  pixel_position;
  logic              have_reference;
  logic [CNT_W-1:0]  running_count;
  logic [PIX_W-1:0]  pixel_threshold;
  logic [CNT_W-1:0]  count_threshold;

  logic              s1_valid;
  logic [PIX_W-1:0]  s1_pixel;
  pix_flags_t        s1_flags;

  logic              accept;
  logic              advance;
  logic              in_range;
  logic [ADDR_W-1:0] addr;
  pix_flags_t        in_flags;
  score_t            score;

  assign cfg_ready = 1'b1;
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !s1_valid || advance;
  assign accept    = s_tvalid && s_tready;
  assign in_range  = (pixel_position < POS_W'(FRAME_PIXELS));
  assign addr      = pixel_position[ADDR_W-1:0];

  assign in_flags.capturing = !have_reference;
  assign in_flags.in_range  = in_range;
  assign in_flags.last      = s_tlast;

  // Reference store: write while capturing, read otherwise. A frame follows
  // the reference one item later, so the read sees the finished write.
  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      if (!have_reference) begin
        ref_mem[addr] <= s_tdata[PIX_W-1:0];
      end else begin
        ref_rdata <= ref_mem[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
      have_reference <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        pixel_position <= '0;
        have_reference <= 1'b1;
      end else if (in_range) begin
        pixel_position <= pixel_position + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_threshold <= PIXEL_THRESHOLD_RST;
      count_threshold <= COUNT_THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PIXEL_THRESHOLD: pixel_threshold <= cfg_data[PIX_W-1:0];
        REG_COUNT_THRESHOLD: count_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: pixel waits for its reference read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= s_tdata[PIX_W-1:0];
      s1_flags <= in_flags;
    end
  end

  fdcd_score u_score (
    .pixel           (s1_pixel),
    .ref_pixel       (ref_rdata),
    .flags           (s1_flags),
    .pixel_threshold (pixel_threshold),
    .count_threshold (count_threshold),
    .running_count   (running_count),
    .score           (score)
  );

  // Stage 2: output register and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid      <= 1'b0;
      running_count <= '0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
      if (s1_valid) begin
        running_count <= score.running_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      m_tdata <= {{(TDATA_OUT_W-PIX_W-CNT_W){1'b0}}, score.changed_count,
                  score.diff_value};
      m_tuser <= {score.frame_changed, score.capturing_reference};
      m_tlast <= score.frame_done;
    end
  end

endmodule

// File: hdl/fdcd_checker.sv
// ----------------------------------------------------------------------------
// fdcd_checker
// Port-level checks on the change detector result stream.
// ----------------------------------------------------------------------------
module fdcd_checker
  import fdcd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [TDATA_OUT_W-1:0] m_tdata,
  input logic [TUSER_OUT_W-1:0] m_tuser,
  input logic                   m_tlast
);

  // hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result changed while stalled");

  a_capture_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
    else $error("reference capture result not zero");

  a_changed_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("frame change flagged off frame end");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[PIX_W+CNT_W-1:PIX_W] <= COUNT_MAX)
    else $error("changed count beyond saturation");

endmodule

bind frame_difference_change_detector_core fdcd_checker u_fdcd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
